>>> src/deq_pkg.sv
// Shared types and constants for the double-ended queue.
// Holds the sizing, command and status codes, and the cell control word.
// No dependencies.
`default_nettype none
package deq_pkg;

   localparam int DEPTH = 64;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int DATA_W = 32;
   localparam int CMD_W = 3;
   localparam int STATUS_W = 3;

   localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
   localparam logic [CMD_W-1:0] CMD_PUSH_REAR = 3'd1;
   localparam logic [CMD_W-1:0] CMD_POP_FRONT = 3'd2;
   localparam logic [CMD_W-1:0] CMD_POP_REAR = 3'd3;
   localparam logic [CMD_W-1:0] CMD_LIST = 3'd4;

   localparam logic [STATUS_W-1:0] STAT_DONE = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_LISTED = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_EMPTY = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_UNDERFLOW = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_FULL = 3'd4;
   localparam logic [STATUS_W-1:0] STAT_HALTED = 3'd5;

   typedef enum logic [1:0] {
      CELL_HOLD = 2'd0,
      CELL_TAKE_LEFT = 2'd1,
      CELL_TAKE_RIGHT = 2'd2
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic load_en;
      logic [IDX_W-1:0] load_idx;
      logic signed [DATA_W-1:0] load_data;
   } chain_ctl_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_LIST = 2'b10
   } state_type;

endpackage
`default_nettype wire

>>> src/deq_if.sv
// Valid/ready channel interfaces for the double-ended queue.
// Depends on deq_pkg for field widths.
`default_nettype none
interface deq_req_if;
   logic valid;
   logic ready;
   logic [deq_pkg::CMD_W-1:0] command;
   logic signed [deq_pkg::DATA_W-1:0] data_value;
   modport source (output valid, output command, output data_value, input ready);
   modport sink (input valid, input command, input data_value, output ready);
endinterface

interface deq_rsp_if;
   logic valid;
   logic ready;
   logic [deq_pkg::STATUS_W-1:0] status;
   logic signed [deq_pkg::DATA_W-1:0] out_value;
   logic last;
   modport source (output valid, output status, output out_value, output last, input ready);
   modport sink (input valid, input status, input out_value, input last, output ready);
endinterface
`default_nettype wire

>>> src/deq_cell.sv
// One storage cell of the queue chain: holds a word, takes a neighbor's or a load.
// Depends on deq_pkg.
`default_nettype none
module deq_cell (
   input wire logic clock,
   input wire deq_pkg::cell_op_type op,
   input wire logic load_en,
   input wire logic signed [deq_pkg::DATA_W-1:0] load_data,
   input wire logic signed [deq_pkg::DATA_W-1:0] left_value,
   input wire logic signed [deq_pkg::DATA_W-1:0] right_value,
   output logic signed [deq_pkg::DATA_W-1:0] value
);

   logic signed [deq_pkg::DATA_W-1:0] value_ff;
   logic signed [deq_pkg::DATA_W-1:0] value_in;

   always_comb begin
      value_in = value_ff;
      if (load_en) begin
         value_in = load_data;
      end else begin
         case (op)
            deq_pkg::CELL_TAKE_LEFT: value_in = left_value;
            deq_pkg::CELL_TAKE_RIGHT: value_in = right_value;
            default: value_in = value_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule
`default_nettype wire

>>> src/deq_chain.sv
// Row of DEPTH queue cells; cell 0 holds the front entry.
// Depends on deq_pkg and deq_cell.
`default_nettype none
module deq_chain (
   input wire logic clock,
   input wire deq_pkg::chain_ctl_type ctl,
   output logic signed [deq_pkg::DATA_W-1:0] front_value
);

   logic signed [deq_pkg::DATA_W-1:0] cell_value [deq_pkg::DEPTH];

   for (genvar i = 0; i < deq_pkg::DEPTH; i++) begin : g_cell
      logic signed [deq_pkg::DATA_W-1:0] left_value;
      logic signed [deq_pkg::DATA_W-1:0] right_value;
      logic load_en;

      if (i == 0) begin : g_first
         assign left_value = '0;
      end else begin : g_mid_l
         assign left_value = cell_value[i-1];
      end
      if (i == deq_pkg::DEPTH - 1) begin : g_last
         assign right_value = '0;
      end else begin : g_mid_r
         assign right_value = cell_value[i+1];
      end

      assign load_en = ctl.load_en && (ctl.load_idx == deq_pkg::IDX_W'(i));

      deq_cell u_cell (
         .clock(clock),
         .op(ctl.op),
         .load_en(load_en),
         .load_data(ctl.load_data),
         .left_value(left_value),
         .right_value(right_value),
         .value(cell_value[i])
      );
   end

   assign front_value = cell_value[0];

endmodule
`default_nettype wire

>>> src/double_ended_queue_top.sv
// Top level of the double-ended queue: command decode, list sequencer, result register.
// Depends on deq_pkg, deq_if and deq_chain.
//
//   channel | direction | words per item                | fields
//   req_if  | in        | 1                             | command, data_value
//   rsp_if  | out       | 1, or one per entry for list  | status, out_value, last
//
// Push and pop update the cell row in place; only the front-end commands shift it.
// List enters the list state, then emits one word per stored entry: the row rotates left
// once per word emitted and is back in its original order after the final word.
// Reset clears count, halt flag and control; cell contents are left as they are.
// A stalled result holds; no new command is taken while list words are pending.
`default_nettype none
module double_ended_queue_top (
   input wire logic clock,
   input wire logic reset,
   deq_req_if.sink req_if,
   deq_rsp_if.source rsp_if
);

   deq_pkg::state_type state_ff, state_in;
   logic [deq_pkg::CNT_W-1:0] count_ff, count_in;
   logic [deq_pkg::CNT_W-1:0] left_ff, left_in;
   logic halted_ff, halted_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [deq_pkg::STATUS_W-1:0] status_ff, status_in;
   logic signed [deq_pkg::DATA_W-1:0] value_ff, value_in;
   logic last_ff, last_in;

   deq_pkg::chain_ctl_type ctl;
   logic signed [deq_pkg::DATA_W-1:0] front_value;
   logic rsp_free;
   logic accept;
   logic [deq_pkg::CNT_W-1:0] count_dec;

   deq_chain u_chain (
      .clock(clock),
      .ctl(ctl),
      .front_value(front_value)
   );

   assign rsp_free = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = (state_ff == deq_pkg::S_IDLE) && rsp_free;
   assign accept = req_if.valid && req_if.ready;
   assign count_dec = count_ff - deq_pkg::CNT_W'(1);

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      left_in = left_ff;
      halted_in = halted_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      status_in = status_ff;
      value_in = value_ff;
      last_in = last_ff;
      ctl.op = deq_pkg::CELL_HOLD;
      ctl.load_en = 1'b0;
      ctl.load_idx = '0;
      ctl.load_data = req_if.data_value;

      case (state_ff)
         deq_pkg::S_IDLE: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               status_in = deq_pkg::STAT_DONE;
               value_in = '0;
               last_in = 1'b1;
               if (halted_ff) begin
                  status_in = deq_pkg::STAT_HALTED;
               end else begin
                  case (req_if.command)
                     deq_pkg::CMD_PUSH_FRONT: begin
                        if (count_ff == deq_pkg::CNT_W'(deq_pkg::DEPTH)) begin
                           status_in = deq_pkg::STAT_FULL;
                        end else begin
                           ctl.op = deq_pkg::CELL_TAKE_LEFT;
                           ctl.load_en = 1'b1;
                           count_in = count_ff + deq_pkg::CNT_W'(1);
                        end
                     end
                     deq_pkg::CMD_PUSH_REAR: begin
                        if (count_ff == deq_pkg::CNT_W'(deq_pkg::DEPTH)) begin
                           status_in = deq_pkg::STAT_FULL;
                        end else begin
                           ctl.load_en = 1'b1;
                           ctl.load_idx = count_ff[deq_pkg::IDX_W-1:0];
                           count_in = count_ff + deq_pkg::CNT_W'(1);
                        end
                     end
                     deq_pkg::CMD_POP_FRONT: begin
                        if (count_ff == '0) begin
                           status_in = deq_pkg::STAT_UNDERFLOW;
                           halted_in = 1'b1;
                        end else begin
                           ctl.op = deq_pkg::CELL_TAKE_RIGHT;
                           count_in = count_dec;
                        end
                     end
                     deq_pkg::CMD_POP_REAR: begin
                        if (count_ff == '0) begin
                           status_in = deq_pkg::STAT_UNDERFLOW;
                           halted_in = 1'b1;
                        end else begin
                           count_in = count_dec;
                        end
                     end
                     deq_pkg::CMD_LIST: begin
                        if (count_ff == '0) begin
                           status_in = deq_pkg::STAT_EMPTY;
                        end else begin
                           rsp_valid_in = 1'b0;
                           left_in = count_ff;
                           state_in = deq_pkg::S_LIST;
                        end
                     end
                     default: status_in = deq_pkg::STAT_DONE;
                  endcase
               end
            end
         end
         deq_pkg::S_LIST: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               status_in = deq_pkg::STAT_LISTED;
               value_in = front_value;
               last_in = (left_ff == deq_pkg::CNT_W'(1));
               ctl.op = deq_pkg::CELL_TAKE_RIGHT;
               ctl.load_en = 1'b1;
               ctl.load_idx = count_dec[deq_pkg::IDX_W-1:0];
               ctl.load_data = front_value;
               left_in = left_ff - deq_pkg::CNT_W'(1);
               if (left_ff == deq_pkg::CNT_W'(1)) begin
                  state_in = deq_pkg::S_IDLE;
               end
            end
         end
         default: state_in = deq_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= deq_pkg::S_IDLE;
         count_ff <= '0;
         left_ff <= '0;
         halted_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         left_ff <= left_in;
         halted_ff <= halted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      value_ff <= value_in;
      last_ff <= last_in;
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.status = status_ff;
   assign rsp_if.out_value = value_ff;
   assign rsp_if.last = last_ff;

endmodule
`default_nettype wire
